>>> hw/rtl/searchable_fifo_queue_core_assert.svh
// ----------------------------------------------------------------------------
// Searchable FIFO queue assertion macros
// Shorthand for clocked implications with asynchronous reset disable.
// ----------------------------------------------------------------------------
`ifndef SEARCHABLE_FIFO_QUEUE_CORE_ASSERT_SVH
`define SEARCHABLE_FIFO_QUEUE_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define SFQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("searchable_fifo_queue_core: check failed");

// Consequent must hold in the cycle after the antecedent
`define SFQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("searchable_fifo_queue_core: check failed");

`endif

>>> hw/rtl/sfq_pkg.sv
// ----------------------------------------------------------------------------
// Searchable FIFO queue package
// Sizes, opcode and status codes, and the command and result records.
// ----------------------------------------------------------------------------
`default_nettype none

package sfq_pkg;

	localparam int DEPTH  = 16;
	localparam int DATA_W = 32;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);

	// Opcode field encodings
	localparam logic [2:0] OPC_PUSH  = 3'd0;
	localparam logic [2:0] OPC_POP   = 3'd1;
	localparam logic [2:0] OPC_FRONT = 3'd2;
	localparam logic [2:0] OPC_FIND  = 3'd3;
	localparam logic [2:0] OPC_SWAP  = 3'd4;
	localparam logic [2:0] OPC_AT    = 3'd5;
	localparam logic [2:0] OPC_CLEAR = 3'd6;

	// Status field encodings
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

	typedef enum logic [2:0] {
		OP_PUSH,
		OP_POP,
		OP_FRONT,
		OP_FIND,
		OP_SWAP,
		OP_AT,
		OP_CLEAR,
		OP_NOP
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [DATA_W-1:0]  data;
		logic [IDX_W-1:0]   index;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_status_t;

	typedef struct packed {
		logic [DATA_W-1:0]  read_data;
		logic [IDX_W-1:0]   found_index;
		logic [1:0]         status;
		logic [CNT_W-1:0]   count;
		logic               is_empty;
	} res_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_LOOK,
		BK_DONE
	} bk_state_t;

endpackage

`default_nettype wire

>>> hw/rtl/sfq_front.sv
// ----------------------------------------------------------------------------
// Searchable FIFO queue front end
// Accepts input transactions and classifies the opcode into a command.
// ----------------------------------------------------------------------------
`default_nettype none

module sfq_front
	import sfq_pkg::*;
(
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [2:0]         opcode,
	input  wire logic [DATA_W-1:0]  data,
	input  wire logic [IDX_W-1:0]   index,
	input  wire fifo_status_t       q_status,
	output logic                    q_wr,
	output cmd_t                    q_cmd
);

	// Stall while the command queue has no room
	assign in_stall = q_status.full;
	assign q_wr     = in_valid && !q_status.full;

	// Classify the opcode; the unused code becomes a no-op
	always_comb begin
		q_cmd.data  = data;
		q_cmd.index = index;
		case (opcode)
			OPC_PUSH:  q_cmd.op = OP_PUSH;
			OPC_POP:   q_cmd.op = OP_POP;
			OPC_FRONT: q_cmd.op = OP_FRONT;
			OPC_FIND:  q_cmd.op = OP_FIND;
			OPC_SWAP:  q_cmd.op = OP_SWAP;
			OPC_AT:    q_cmd.op = OP_AT;
			OPC_CLEAR: q_cmd.op = OP_CLEAR;
			default:   q_cmd.op = OP_NOP;
		endcase
	end

endmodule

`default_nettype wire

>>> hw/rtl/sfq_cmd_fifo.sv
// ----------------------------------------------------------------------------
// Searchable FIFO queue command buffer
// Two-entry queue that decouples the front end from the execution unit.
// ----------------------------------------------------------------------------
`default_nettype none

module sfq_cmd_fifo
	import sfq_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   wr,
	input  wire cmd_t   wr_cmd,
	input  wire logic   rd,
	output cmd_t        rd_cmd,
	output fifo_status_t status
);

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] level_q;
	logic       do_wr;
	logic       do_rd;

	assign status.full  = (level_q == 2'd2);
	assign status.empty = (level_q == 2'd0);
	assign do_wr        = wr && !status.full;
	assign do_rd        = rd && !status.empty;
	assign rd_cmd       = slot_q[rd_ptr_q];

	// Store the incoming command
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_cmd;
		end
	end

	// Advance pointers and track the fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			level_q  <= 2'd0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_rd) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_wr, do_rd})
				2'b10:   level_q <= level_q + 2'd1;
				2'b01:   level_q <= level_q - 2'd1;
				default: level_q <= level_q;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/sfq_back.sv
// ----------------------------------------------------------------------------
// Searchable FIFO queue execution unit
// Holds the queue cells and carries out one command at a time: lookup, then update.
// ----------------------------------------------------------------------------
`default_nettype none

module sfq_back
	import sfq_pkg::*;
(
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire fifo_status_t   q_status,
	input  wire cmd_t           q_cmd,
	output logic                q_rd,
	input  wire logic           out_stall,
	output logic                out_valid,
	output res_t                res
);

	bk_state_t          state_q;
	bk_state_t          state_d;
	cmd_t               cmd_q;
	logic [DATA_W-1:0]  ent_q [DEPTH];
	logic [DATA_W-1:0]  ent_d [DEPTH];
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   count_d;
	logic [DEPTH-1:0]   match_d;
	logic [DEPTH-1:0]   match_q;
	logic [DATA_W-1:0]  at_word_q;
	logic               out_valid_q;
	res_t               res_q;
	res_t               res_d;
	logic               out_free;
	logic               commit;
	logic               take_cmd;
	logic               pos_in_range;
	logic               push_ok;
	logic               pop_ok;
	logic               swap_ok;
	logic [IDX_W-1:0]   first_hit;

	assign out_free = !out_valid_q || !out_stall;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (!q_status.empty) begin
					state_d = BK_LOOK;
				end
			end
			BK_LOOK: state_d = BK_DONE;
			BK_DONE: begin
				if (out_free) begin
					state_d = q_status.empty ? BK_IDLE : BK_LOOK;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		commit   = 1'b0;
		take_cmd = 1'b0;
		case (state_q)
			BK_IDLE: take_cmd = !q_status.empty;
			BK_DONE: begin
				commit   = out_free;
				take_cmd = out_free && !q_status.empty;
			end
			default: begin
				commit   = 1'b0;
				take_cmd = 1'b0;
			end
		endcase
	end

	assign q_rd = take_cmd;

	// Classify the command against the current fill level
	assign pos_in_range = CNT_W'(cmd_q.index) < count_q;
	assign push_ok = (cmd_q.op == OP_PUSH) && (count_q != CNT_W'(DEPTH));
	assign pop_ok  = (cmd_q.op == OP_POP) && (count_q != '0);
	assign swap_ok = (cmd_q.op == OP_SWAP) && (cmd_q.index != '0) && pos_in_range;

	// Compare every live cell with the search word
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			match_d[i] = (ent_q[i] == cmd_q.data) && (CNT_W'(i) < count_q);
		end
	end

	// Pick the lowest matching position
	always_comb begin
		first_hit = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (match_q[i]) begin
				first_hit = IDX_W'(i);
			end
		end
	end

	// Per-cell next value: append, shift toward head, or swap with a neighbor
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		localparam int UP = (g < DEPTH - 1) ? g + 1 : g;
		localparam int DN = (g > 0) ? g - 1 : g;
		always_comb begin
			ent_d[g] = ent_q[g];
			if (push_ok && (count_q == CNT_W'(g))) begin
				ent_d[g] = cmd_q.data;
			end else if (pop_ok) begin
				ent_d[g] = ent_q[UP];
			end else if (swap_ok && (cmd_q.index == IDX_W'(g))) begin
				ent_d[g] = ent_q[DN];
			end else if (swap_ok && (cmd_q.index == IDX_W'(g + 1))) begin
				ent_d[g] = ent_q[UP];
			end
		end
	end

	// Result and new count
	always_comb begin
		count_d           = count_q;
		res_d.read_data   = '0;
		res_d.found_index = '0;
		res_d.status      = ST_OK;
		case (cmd_q.op)
			OP_PUSH: begin
				if (push_ok) begin
					count_d = count_q + CNT_W'(1);
				end else begin
					res_d.status = ST_FULL;
				end
			end
			OP_POP: begin
				if (pop_ok) begin
					res_d.read_data = ent_q[0];
					count_d         = count_q - CNT_W'(1);
				end else begin
					res_d.status = ST_EMPTY;
				end
			end
			OP_FRONT: begin
				if (count_q != '0) begin
					res_d.read_data = ent_q[0];
				end else begin
					res_d.status = ST_EMPTY;
				end
			end
			OP_FIND: begin
				if (|match_q) begin
					res_d.found_index = first_hit;
				end else begin
					res_d.status = ST_EMPTY;
				end
			end
			OP_SWAP: begin
				if (!swap_ok) begin
					res_d.status = ST_RANGE;
				end
			end
			OP_AT: begin
				if (pos_in_range) begin
					res_d.read_data = at_word_q;
				end else begin
					res_d.status = ST_RANGE;
				end
			end
			OP_CLEAR: count_d = '0;
			default:  count_d = count_q;
		endcase
		res_d.count    = count_d;
		res_d.is_empty = (count_d == '0);
	end

	// Hold the command, lookup results, cells and result register
	always_ff @(posedge clk) begin
		if (take_cmd) begin
			cmd_q <= q_cmd;
		end
		if (state_q == BK_LOOK) begin
			match_q   <= match_d;
			at_word_q <= ent_q[cmd_q.index];
		end
		if (commit) begin
			ent_q <= ent_d;
			res_q <= res_d;
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (commit) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign res       = res_q;

endmodule

`default_nettype wire

>>> hw/rtl/searchable_fifo_queue_core.sv
// ----------------------------------------------------------------------------
// Searchable FIFO queue core
// Ordered word queue with push, pop, front, find, swap, read-at and clear.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries opcode, data and index; a
//   transaction is taken at a clock edge with in_valid high and in_stall low.
//   Output channel (out_valid / out_stall) returns exactly one result per
//   command: read_data, found_index, status, count and is_empty.
//   A two-entry command buffer sits between the front end and the execution
//   unit, so new commands are taken while a result waits on out_stall.
//   The execution unit handles one command at a time: it compares all cells
//   in its lookup state and updates them when the result is committed.
//   While out_stall holds, the result register holds and the execution unit
//   waits; the input side stalls once the command buffer is full.
//   Reset empties the queue and the command buffer and drops out_valid.
// ----------------------------------------------------------------------------
`default_nettype none

module searchable_fifo_queue_core
	import sfq_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [2:0]         opcode,
	input  wire logic [DATA_W-1:0]  data,
	input  wire logic [IDX_W-1:0]   index,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [DATA_W-1:0]       read_data,
	output logic [IDX_W-1:0]        found_index,
	output logic [1:0]              status,
	output logic [CNT_W-1:0]        count,
	output logic                    is_empty
);

	fifo_status_t q_status;
	cmd_t         wr_cmd;
	cmd_t         rd_cmd;
	logic         q_wr;
	logic         q_rd;
	res_t         res;

	sfq_front u_front (
		.in_valid (in_valid),
		.in_stall (in_stall),
		.opcode   (opcode),
		.data     (data),
		.index    (index),
		.q_status (q_status),
		.q_wr     (q_wr),
		.q_cmd    (wr_cmd)
	);

	sfq_cmd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.wr_cmd (wr_cmd),
		.rd     (q_rd),
		.rd_cmd (rd_cmd),
		.status (q_status)
	);

	sfq_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_status  (q_status),
		.q_cmd     (rd_cmd),
		.q_rd      (q_rd),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.res       (res)
	);

	// Unpack the result record onto the ports
	assign read_data   = res.read_data;
	assign found_index = res.found_index;
	assign status      = res.status;
	assign count       = res.count;
	assign is_empty    = res.is_empty;

endmodule

`default_nettype wire

>>> hw/rtl/sfq_checker.sv
// ----------------------------------------------------------------------------
// Searchable FIFO queue port checker
// Watches the output channel of the core for consistent results.
// ----------------------------------------------------------------------------
`default_nettype none

`include "searchable_fifo_queue_core_assert.svh"

module sfq_checker
	import sfq_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               out_valid,
	input  wire logic               out_stall,
	input  wire logic [DATA_W-1:0]  read_data,
	input  wire logic [IDX_W-1:0]   found_index,
	input  wire logic [1:0]         status,
	input  wire logic [CNT_W-1:0]   count,
	input  wire logic               is_empty
);

	// A stalled result holds until taken
	`SFQ_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(read_data) && $stable(status) && $stable(count))

	// Empty flag tracks the reported count
	`SFQ_ASSERT_SAME(a_empty_flag, clk, arst_n, out_valid, is_empty == (count == '0))

	// Full is reported only at capacity
	`SFQ_ASSERT_SAME(a_full_count, clk, arst_n, out_valid && (status == ST_FULL), count == CNT_W'(DEPTH))

	// Failed lookups return no data and no position
	`SFQ_ASSERT_SAME(a_fail_zero, clk, arst_n, out_valid && (status == ST_EMPTY || status == ST_RANGE), read_data == '0 && found_index == '0)

endmodule

bind searchable_fifo_queue_core sfq_checker u_sfq_checker (.*);

`default_nettype wire

>>> verif/searchable_fifo_queue_core_tb.sv
// ----------------------------------------------------------------------------
// Searchable FIFO queue core testbench
// Drives opcode, data and index transactions into the core and checks each
// result against a cycle-free model of the ordered queue. A directed opening
// covers the empty, full and range corners. Random traffic follows, drawn
// from a small word pool so that finds hit. Both channels idle in random
// bursts, and two long output holds back the core up into its input.
// ----------------------------------------------------------------------------
`default_nettype none

module searchable_fifo_queue_core_tb;
	import sfq_pkg::*;

	localparam int RANDOM_ITEMS   = 1916;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 60;

	typedef struct {
		op_t               op;
		logic [DATA_W-1:0] word;
		logic [IDX_W-1:0]  pos;
		bit                drain;
	} queue_cmd_t;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_stall;
	logic [2:0]         opcode    = OPC_PUSH;
	logic [DATA_W-1:0]  data      = '0;
	logic [IDX_W-1:0]   index     = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [DATA_W-1:0]  read_data;
	logic [IDX_W-1:0]   found_index;
	logic [1:0]         status;
	logic [CNT_W-1:0]   count;
	logic               is_empty;

	// Queue model state
	logic [DATA_W-1:0]  model_words [DEPTH];
	int                 model_fill = 0;

	queue_cmd_t         ops_to_send [$];
	res_t               results_due [$];
	queue_cmd_t         cur_cmd;
	res_t               want;
	res_t               seen;

	int                 total_items = 0;
	int                 cmds_sent = 0;
	int                 results_checked = 0;
	int                 errors = 0;
	int                 gap_left = 0;
	int                 stall_left = 0;
	int                 hold_left = 0;
	int                 next_hold_at = 400;
	int                 quiet_cycles = 0;
	int                 op_tally [8];
	int                 status_tally [4];
	logic               long_hold = 1'b0;

	searchable_fifo_queue_core u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.data        (data),
		.index       (index),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.read_data   (read_data),
		.found_index (found_index),
		.status      (status),
		.count       (count),
		.is_empty    (is_empty)
	);

	always #10 clk = ~clk;

	// Apply one command to the queue model and return the result it gives
	function automatic res_t apply_queue_op(input queue_cmd_t c);
		res_t r;
		logic [DATA_W-1:0] t;
		int k;
		r = '0;
		r.status = ST_OK;
		case (c.op)
			OP_PUSH: begin
				if (model_fill >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					model_words[model_fill] = c.word;
					model_fill++;
				end
			end
			OP_POP: begin
				if (model_fill == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.read_data = model_words[0];
					for (k = 1; k < model_fill; k++)
						model_words[k-1] = model_words[k];
					model_fill--;
				end
			end
			OP_FRONT: begin
				if (model_fill == 0)
					r.status = ST_EMPTY;
				else
					r.read_data = model_words[0];
			end
			OP_FIND: begin
				r.status = ST_EMPTY;
				for (k = 0; k < model_fill; k++) begin
					if (r.status == ST_EMPTY && model_words[k] == c.word) begin
						r.found_index = IDX_W'(k);
						r.status = ST_OK;
					end
				end
			end
			OP_SWAP: begin
				if (c.pos == 0 || c.pos >= model_fill) begin
					r.status = ST_RANGE;
				end else begin
					t = model_words[c.pos-1];
					model_words[c.pos-1] = model_words[c.pos];
					model_words[c.pos] = t;
				end
			end
			OP_AT: begin
				if (c.pos >= model_fill)
					r.status = ST_RANGE;
				else
					r.read_data = model_words[c.pos];
			end
			OP_CLEAR: model_fill = 0;
			default: ;
		endcase
		r.count = CNT_W'(model_fill);
		r.is_empty = (model_fill == 0);
		return r;
	endfunction

	function automatic queue_cmd_t make_op(input op_t op, input logic [DATA_W-1:0] word,
			input logic [IDX_W-1:0] pos);
		queue_cmd_t c;
		c.op = op;
		c.word = word;
		c.pos = pos;
		c.drain = 1'b0;
		return c;
	endfunction

	// No idling once the stimulus is nearly used up
	function automatic bit quiet_tail();
		return ops_to_send.size() < 150;
	endfunction

	// Stimulus, reset and end of run
	initial begin
		logic [DATA_W-1:0] word_pool [8];
		logic [DATA_W-1:0] last_word;
		queue_cmd_t c;
		int n;
		int roll;
		int push_weight;
		int sim_fill;

		for (n = 0; n < 8; n++) begin
			op_tally[n] = 0;
			word_pool[n] = $urandom();
		end
		for (n = 0; n < 4; n++)
			status_tally[n] = 0;
		word_pool[0] = '0;
		word_pool[1] = '1;

		// Directed: empty-queue corners, fill to full, range checks, clear
		ops_to_send.push_back(make_op(OP_POP, '1, '1));
		ops_to_send.push_back(make_op(OP_FRONT, '0, '0));
		ops_to_send.push_back(make_op(OP_FIND, '0, '0));
		ops_to_send.push_back(make_op(OP_SWAP, '0, 4'd1));
		ops_to_send.push_back(make_op(OP_AT, '0, '0));
		ops_to_send.push_back(make_op(OP_NOP, '1, '1));
		last_word = '0;
		for (n = 0; n < DEPTH; n++) begin
			last_word = (n == 0) ? '0 : (n == 1) ? '1 : 32'h0F0F_0000 + n * 32'h0101_0101;
			ops_to_send.push_back(make_op(OP_PUSH, last_word, IDX_W'(n)));
		end
		ops_to_send.push_back(make_op(OP_PUSH, 32'hA5A5_5A5A, '0));
		ops_to_send.push_back(make_op(OP_FIND, last_word, '0));
		ops_to_send.push_back(make_op(OP_FIND, 32'h1234_5678, '0));
		ops_to_send.push_back(make_op(OP_SWAP, '1, '0));
		ops_to_send.push_back(make_op(OP_SWAP, '0, 4'd15));
		ops_to_send.push_back(make_op(OP_AT, '0, 4'd15));
		ops_to_send.push_back(make_op(OP_AT, '0, '0));
		ops_to_send.push_back(make_op(OP_FRONT, '0, '0));
		ops_to_send.push_back(make_op(OP_POP, '0, '0));
		ops_to_send.push_back(make_op(OP_AT, '0, 4'd15));
		ops_to_send.push_back(make_op(OP_SWAP, '0, 4'd15));
		ops_to_send.push_back(make_op(OP_CLEAR, '1, '1));

		// Random: op mix steered by the expected fill so the queue swings
		// between nearly empty and full
		sim_fill = 0;
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			roll = $urandom_range(0, 99);
			push_weight = (sim_fill < 4) ? 45 : (sim_fill > 12) ? 15 : 28;
			c.drain = (n == 0) || (n == 1000) || (n == 1600);
			c.pos = IDX_W'($urandom());
			c.word = ($urandom_range(0, 3) == 0) ? $urandom() : word_pool[$urandom_range(0, 7)];
			if (roll < 1)
				c.op = OP_NOP;
			else if (roll < 3)
				c.op = OP_CLEAR;
			else if (roll < 3 + push_weight)
				c.op = OP_PUSH;
			else begin
				case ((roll - 3 - push_weight) % 5)
					0: c.op = OP_POP;
					1: c.op = OP_FRONT;
					2: c.op = OP_FIND;
					3: c.op = OP_SWAP;
					default: c.op = OP_AT;
				endcase
			end
			// Keep most positions inside the filled part
			if ($urandom_range(0, 4) != 0) begin
				if (c.op == OP_SWAP && sim_fill > 1)
					c.pos = IDX_W'($urandom_range(1, sim_fill - 1));
				else if (c.op == OP_AT && sim_fill > 0)
					c.pos = IDX_W'($urandom_range(0, sim_fill - 1));
			end
			case (c.op)
				OP_PUSH: if (sim_fill < DEPTH) sim_fill++;
				OP_POP: if (sim_fill > 0) sim_fill--;
				OP_CLEAR: sim_fill = 0;
				default: ;
			endcase
			ops_to_send.push_back(c);
		end
		total_items = ops_to_send.size();

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (cmds_sent != total_items)
			@(posedge clk);
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);

		$display("Covered %0d commands: push %0d pop %0d front %0d find %0d swap %0d at %0d clear %0d nop %0d",
			cmds_sent, op_tally[0], op_tally[1], op_tally[2], op_tally[3],
			op_tally[4], op_tally[5], op_tally[6], op_tally[7]);
		$display("Result status seen: ok %0d empty/miss %0d full %0d range %0d; mismatches %0d",
			status_tally[0], status_tally[1], status_tally[2], status_tally[3], errors);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Driver: predict on acceptance, hold while stalled, then idle or offer the next
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			opcode <= OPC_PUSH;
			data <= '0;
			index <= '0;
			gap_left = 0;
		end else begin
			if (in_valid && !in_stall) begin
				results_due.push_back(apply_queue_op(cur_cmd));
				op_tally[cur_cmd.op]++;
				cmds_sent++;
			end
			if (in_valid && in_stall) begin
				// hold the stalled transaction
			end else if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (ops_to_send.size() == 0
					|| (ops_to_send[0].drain && results_due.size() != 0)) begin
				in_valid <= 1'b0;
			end else if (!long_hold && !quiet_tail() && ((cmds_sent / 160) % 3) != 2
					&& $urandom_range(0, 5) == 0) begin
				gap_left = $urandom_range(0, 13);
				in_valid <= 1'b0;
			end else begin
				cur_cmd = ops_to_send.pop_front();
				in_valid <= 1'b1;
				opcode <= cur_cmd.op;
				data <= cur_cmd.word;
				index <= cur_cmd.pos;
			end
		end
	end

	// Monitor: check accepted results, then choose the next stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			long_hold <= 1'b0;
			stall_left = 0;
			hold_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				seen.read_data = read_data;
				seen.found_index = found_index;
				seen.status = status;
				seen.count = count;
				seen.is_empty = is_empty;
				status_tally[status]++;
				if (results_due.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("ERROR: unexpected result data=%h idx=%0d st=%0d cnt=%0d empty=%b",
							read_data, found_index, status, count, is_empty);
				end else begin
					want = results_due.pop_front();
					if (seen.read_data !== want.read_data || seen.found_index !== want.found_index
							|| seen.status !== want.status || seen.count !== want.count
							|| seen.is_empty !== want.is_empty) begin
						errors++;
						if (errors <= 10)
							$display("ERROR: result %0d exp data=%h idx=%0d st=%0d cnt=%0d empty=%b, got data=%h idx=%0d st=%0d cnt=%0d empty=%b",
								results_checked, want.read_data, want.found_index, want.status,
								want.count, want.is_empty, seen.read_data, seen.found_index,
								seen.status, seen.count, seen.is_empty);
					end
				end
				results_checked++;
			end
			// Long hold backs the core up into its input side
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
				long_hold <= (hold_left != 0);
			end else if (results_checked >= next_hold_at) begin
				next_hold_at += 900;
				hold_left = HOLD_CYCLES - 1;
				out_stall <= 1'b1;
				long_hold <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (!quiet_tail() && ((results_checked / 200) % 3) != 1
					&& $urandom_range(0, 6) == 0) begin
				stall_left = $urandom_range(0, 13);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog: end the run when no transaction moves for too long
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule

`default_nettype wire

>>> files.f
+incdir+hw/rtl
hw/rtl/sfq_pkg.sv
hw/rtl/sfq_front.sv
hw/rtl/sfq_cmd_fifo.sv
hw/rtl/sfq_back.sv
hw/rtl/searchable_fifo_queue_core.sv
hw/rtl/sfq_checker.sv
verif/searchable_fifo_queue_core_tb.sv
